FILE: hw/rtl/length_crc_frame_checker_top_defines.svh
// Assertion macros for the length and CRC frame checker.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef LENGTH_CRC_FRAME_CHECKER_TOP_DEFINES_SVH
`define LENGTH_CRC_FRAME_CHECKER_TOP_DEFINES_SVH

// Implication in the same cycle.
`define LCFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define LCFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lcfc_pkg.sv
// Shared types, constants and the byte-wise CRC-32 function of the frame checker.
// No dependencies.
package lcfc_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_PAY,
        PH_CRC
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_CRC_BAD,
        ST_CLOSED_IDLE,
        ST_SHORT_LEN,
        ST_SHORT_PAY,
        ST_SHORT_CRC
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic       frame_done;
        t_status    status;
    } t_result;

    // Reflected CRC-32 update by one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/lcfc_if.sv
// Stream interfaces for the received bytes and the checker results.
// No dependencies.
interface lcfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface lcfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_payload;
    logic       frame_done;
    logic [2:0] status;

    modport source (output valid, output out_byte, output is_payload, output frame_done,
                    output status, input ready);
    modport sink (input valid, input out_byte, input is_payload, input frame_done,
                  input status, output ready);
endinterface

FILE: hw/rtl/lcfc_frame_fsm.sv
// Frame parser: phase, field position, length, running and received CRC.
// Depends on lcfc_pkg.
module lcfc_frame_fsm
    import lcfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_end,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_rx, n_rx;
    logic [31:0] rx_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_idx   <= 3'd0;
            r_rem   <= 64'd0;
            r_crc   <= CRC_INIT;
            r_rx    <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
            r_crc   <= n_crc;
            r_rx    <= n_rx;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_crc       = r_crc;
        n_rx        = r_rx;
        rx_full     = r_rx | ({24'd0, i_in_byte} << {r_idx[1:0], 3'b000});
        o_res_valid = 1'b0;
        o_res       = '{out_byte: 8'd0, is_payload: 1'b0, frame_done: 1'b0, status: ST_OK};
        if (i_accept) begin
            if (i_stream_end) begin
                o_res_valid      = 1'b1;
                o_res.frame_done = 1'b1;
                case (r_phase)
                    PH_PAY: begin
                        o_res.status = ST_SHORT_PAY;
                    end
                    PH_CRC: begin
                        o_res.status = ST_SHORT_CRC;
                    end
                    default: begin
                        o_res.status = (r_idx == 3'd0) ? ST_CLOSED_IDLE : ST_SHORT_LEN;
                    end
                endcase
                n_phase = PH_LEN;
                n_idx   = 3'd0;
                n_rem   = 64'd0;
                n_crc   = CRC_INIT;
                n_rx    = 32'd0;
            end else begin
                case (r_phase)
                    PH_PAY: begin
                        n_crc            = crc_byte(r_crc, i_in_byte);
                        n_rem            = r_rem - 64'd1;
                        o_res_valid      = 1'b1;
                        o_res.out_byte   = i_in_byte;
                        o_res.is_payload = 1'b1;
                        if (r_rem == 64'd1) begin
                            n_phase = PH_CRC;
                            n_idx   = 3'd0;
                        end
                    end
                    PH_CRC: begin
                        if (r_idx == 3'd3) begin
                            o_res_valid      = 1'b1;
                            o_res.frame_done = 1'b1;
                            o_res.status     = ((r_crc ^ CRC_INIT) == rx_full) ? ST_OK
                                                                              : ST_CRC_BAD;
                            n_phase = PH_LEN;
                            n_idx   = 3'd0;
                            n_rem   = 64'd0;
                            n_crc   = CRC_INIT;
                            n_rx    = 32'd0;
                        end else begin
                            n_rx  = rx_full;
                            n_idx = r_idx + 3'd1;
                        end
                    end
                    default: begin
                        n_rem = r_rem | ({56'd0, i_in_byte} << {r_idx, 3'b000});
                        n_idx = r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            n_phase = (n_rem == 64'd0) ? PH_CRC : PH_PAY;
                        end
                    end
                endcase
            end
        end
    end

endmodule

FILE: hw/rtl/lcfc_result_buf.sv
// Two-entry result buffer that decouples the parser from the output handshake.
// Depends on lcfc_pkg.
module lcfc_result_buf
    import lcfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_res
);

    t_result    r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_room  = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid & i_ready;

    always_comb begin
        n_wr  = r_wr ^ i_push;
        n_rd  = r_rd ^ pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

FILE: hw/rtl/length_crc_frame_checker_top.sv
// Top level of the length-prefixed frame checker with CRC-32.
// Depends on lcfc_pkg, lcfc_if, lcfc_frame_fsm, lcfc_result_buf and the defines header.
//
//   Channel  Direction  Item
//   i_in     in         one received byte or a stream end marker
//   o_out    out        a payload byte or a frame done status
//
// One item is taken per cycle when ready and gives at most one result, which enters the
// result buffer at the accepting edge and can be taken from o_out from the next cycle on.
// The parser updates its state and forms the result in the cycle of acceptance.
// The two-entry result buffer absorbs a short stall on o_out; i_in.ready drops only when
// both entries hold results not yet taken, and rises in the cycle after one is taken.
// Synchronous active-low reset returns the checker to the start of a length field.
`include "length_crc_frame_checker_top_defines.svh"

module length_crc_frame_checker_top
    import lcfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    lcfc_in_if.sink           i_in,
    lcfc_out_if.source        o_out
);

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    buf_room;
    t_result out_res;

    assign accept     = i_in.valid & i_in.ready;
    assign i_in.ready = buf_room;

    lcfc_frame_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_byte    (i_in.in_byte),
        .i_stream_end (i_in.stream_end),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    lcfc_result_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .i_ready (o_out.ready),
        .o_room  (buf_room),
        .o_valid (o_out.valid),
        .o_res   (out_res)
    );

    assign o_out.out_byte   = out_res.out_byte;
    assign o_out.is_payload = out_res.is_payload;
    assign o_out.frame_done = out_res.frame_done;
    assign o_out.status     = out_res.status;

    `LCFC_ASSERT_IMP(a_kind_exclusive, o_out.valid,
        !(o_out.is_payload && o_out.frame_done), "result is both payload and done")
    `LCFC_ASSERT_NXT(a_end_gives_done, accept && i_in.stream_end, o_out.valid,
        "stream end gave no result")
    `LCFC_ASSERT_IMP(a_stall_has_result, !i_in.ready, o_out.valid,
        "input stalled with no pending result")

endmodule
